[rtl/i2c_trace_decoder_defines.svh]
// Assertion macros for the I2C trace decoder.
`ifndef I2C_TRACE_DECODER_DEFINES_SVH
`define I2C_TRACE_DECODER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define I2CTD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define I2CTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2ctd_pkg.sv]
// Types and constants for the I2C trace decoder.
package i2ctd_pkg;

  // Decoder phases
  typedef enum logic [3:0] {
    PhIdle      = 4'd0,
    PhAddr      = 4'd1,
    PhRw        = 4'd2,
    PhAack      = 4'd3,
    PhData      = 4'd4,
    PhByte      = 4'd5,
    PhWait      = 4'd6,
    PhStop      = 4'd7,
    PhEndNoack  = 4'd8,
    PhEndNostop = 4'd9
  } phase_e;

  // Result status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNoStart   = 3'd1;
  localparam logic [2:0] StNoAddrAck = 3'd2;
  localparam logic [2:0] StNoDataAck = 3'd3;
  localparam logic [2:0] StNoStop    = 3'd4;
  localparam logic [2:0] StAddrCut   = 3'd5;

  // Stop pattern, bit p is the expected level at stop position p
  localparam logic [3:0] StopClock = 4'b1110;
  localparam logic [3:0] StopData  = 4'b1100;

  // Sample counts of the decoding steps
  localparam logic [2:0] AddrLastBit  = 3'd6;
  localparam logic [4:0] ByteSkip     = 5'd16;
  localparam logic [4:0] AckSkip      = 5'd2;
  localparam logic [4:0] BitSkip      = 5'd1;
  localparam int unsigned ByteSpan    = 14;
  localparam int unsigned StopSpan    = 4;

  localparam logic [11:0] TraceLengthReset = 12'd2048;

  typedef struct packed {
    logic clock_line;
    logic data_line;
  } sample_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] target_address;
    logic       is_read;
    logic [7:0] byte_count;
  } result_t;

endpackage

[rtl/i2c_trace_decoder.sv]
// I2C trace decoder: input register, one decode step, result register.
// A sample waits in the input register until decoded into the decode registers;
//   on the trace's last sample the result register loads and out_valid_o rises.
// Throughput: one sample per cycle unless stalled; single-step phase update sets it.
// Reset: all decode state clears, trace_length returns to 2048, no result pending.
`include "i2c_trace_decoder_defines.svh"

module i2c_trace_decoder #(
  parameter int unsigned MAX_SAMPLES = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2ctd_pkg::sample_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2ctd_pkg::result_t  out_res_o
);

  localparam int unsigned IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned LenW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CmpW = ((LenW > 12) ? LenW : 12) + 1;
  localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_SAMPLES);

  // Registers
  logic [11:0]         trace_length_q;
  logic                in_valid_q;
  i2ctd_pkg::sample_t  sample_q;
  i2ctd_pkg::phase_e   phase_q, phase_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [4:0]          skip_q, skip_d;
  logic [2:0]          bit_q, bit_d;
  logic [6:0]          addr_q, addr_d;
  logic                dir_q, dir_d;
  logic [7:0]          bytes_q, bytes_d;
  logic [1:0]          stop_pos_q, stop_pos_d;
  logic                stop_mis_q, stop_mis_d;
  logic                out_valid_q;
  i2ctd_pkg::result_t  res_q, res_d;

  logic            advance;
  logic            fire;
  logic            last;
  logic [CmpW-1:0] len;
  logic [CmpW-1:0] i_ext;
  logic            cl, da;

  // Stage moves on when the result register is free or being emptied
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign cl         = sample_q.clock_line;
  assign da         = sample_q.data_line;

  // Clamp the trace length into 1..MAX_SAMPLES
  always_comb begin
    if (trace_length_q == 12'd0) begin
      len = CmpW'(1);
    end else if (CmpW'(trace_length_q) > MaxLen) begin
      len = MaxLen;
    end else begin
      len = CmpW'(trace_length_q);
    end
  end

  assign i_ext = CmpW'(idx_q);
  assign last  = (i_ext + CmpW'(1)) >= len;

  // Decode one sample, then report and clear on the trace's last sample
  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    bit_d      = bit_q;
    addr_d     = addr_q;
    dir_d      = dir_q;
    bytes_d    = bytes_q;
    stop_pos_d = stop_pos_q;
    stop_mis_d = stop_mis_q;
    idx_d      = idx_q + IdxW'(1);
    res_d      = '0;

    if (skip_q != 5'd0) begin
      skip_d = skip_q - 5'd1;
    end else begin
      case (phase_q)
        i2ctd_pkg::PhIdle: begin
          if (!da && cl) begin
            phase_d = i2ctd_pkg::PhAddr;
            bit_d   = 3'd0;
            addr_d  = 7'd0;
          end
        end
        i2ctd_pkg::PhAddr: begin
          addr_d = {addr_q[5:0], da};
          if (bit_q >= i2ctd_pkg::AddrLastBit) begin
            bit_d   = 3'd0;
            phase_d = i2ctd_pkg::PhRw;
          end else begin
            bit_d = bit_q + 3'd1;
          end
          skip_d = i2ctd_pkg::BitSkip;
        end
        i2ctd_pkg::PhRw: begin
          dir_d   = da;
          skip_d  = i2ctd_pkg::AckSkip;
          phase_d = i2ctd_pkg::PhAack;
        end
        i2ctd_pkg::PhAack: begin
          if (da) begin
            phase_d = i2ctd_pkg::PhEndNoack;
          end else begin
            phase_d = i2ctd_pkg::PhData;
            bytes_d = 8'd0;
          end
        end
        i2ctd_pkg::PhData: begin
          if (i_ext + CmpW'(i2ctd_pkg::ByteSpan) > len) begin
            if (i_ext + CmpW'(i2ctd_pkg::StopSpan) == len) begin
              phase_d    = i2ctd_pkg::PhStop;
              stop_mis_d = (cl != i2ctd_pkg::StopClock[0]) || (da != i2ctd_pkg::StopData[0]);
              stop_pos_d = 2'd1;
            end else begin
              phase_d = i2ctd_pkg::PhEndNostop;
            end
          end else begin
            if (bytes_q != 8'hFF) begin
              bytes_d = bytes_q + 8'd1;
            end
            skip_d  = i2ctd_pkg::ByteSkip;
            phase_d = i2ctd_pkg::PhByte;
          end
        end
        i2ctd_pkg::PhByte: begin
          if (cl && da) begin
            skip_d = i2ctd_pkg::BitSkip;
          end else if (cl && !da) begin
            phase_d = i2ctd_pkg::PhData;
          end else begin
            phase_d = i2ctd_pkg::PhWait;
          end
        end
        i2ctd_pkg::PhWait: begin
          if (cl && !da) begin
            phase_d = i2ctd_pkg::PhData;
          end
        end
        i2ctd_pkg::PhStop: begin
          if ((cl != i2ctd_pkg::StopClock[stop_pos_q]) ||
              (da != i2ctd_pkg::StopData[stop_pos_q])) begin
            stop_mis_d = 1'b1;
          end
          stop_pos_d = stop_pos_q + 2'd1;
        end
        default: begin
        end
      endcase
    end

    // Map the final phase to a status
    case (phase_d)
      i2ctd_pkg::PhIdle:      res_d.status = i2ctd_pkg::StNoStart;
      i2ctd_pkg::PhAddr:      res_d.status = i2ctd_pkg::StAddrCut;
      i2ctd_pkg::PhRw,
      i2ctd_pkg::PhAack,
      i2ctd_pkg::PhEndNoack:  res_d.status = i2ctd_pkg::StNoAddrAck;
      i2ctd_pkg::PhData,
      i2ctd_pkg::PhEndNostop: res_d.status = i2ctd_pkg::StNoStop;
      i2ctd_pkg::PhStop: begin
        res_d.status = (!stop_mis_d && stop_pos_d == 2'd0) ?
                       i2ctd_pkg::StOk : i2ctd_pkg::StNoDataAck;
      end
      default:                res_d.status = i2ctd_pkg::StNoDataAck;
    endcase
    if (res_d.status == i2ctd_pkg::StOk || res_d.status == i2ctd_pkg::StNoAddrAck) begin
      res_d.target_address = addr_d;
    end
    if (res_d.status == i2ctd_pkg::StOk) begin
      res_d.is_read    = dir_d;
      res_d.byte_count = bytes_d;
    end

    // Clear the trace state after the last sample
    if (last) begin
      phase_d    = i2ctd_pkg::PhIdle;
      idx_d      = '0;
      skip_d     = 5'd0;
      bit_d      = 3'd0;
      addr_d     = 7'd0;
      dir_d      = 1'b0;
      bytes_d    = 8'd0;
      stop_pos_d = 2'd0;
      stop_mis_d = 1'b0;
    end
  end

  // Hold the configured trace length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_length_q <= i2ctd_pkg::TraceLengthReset;
    end else if (cfg_we_i) begin
      trace_length_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sample_q <= in_req_i;
    end
  end

  // Decode state, advanced once per decoded sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= i2ctd_pkg::PhIdle;
      idx_q      <= '0;
      skip_q     <= 5'd0;
      bit_q      <= 3'd0;
      addr_q     <= 7'd0;
      dir_q      <= 1'b0;
      bytes_q    <= 8'd0;
      stop_pos_q <= 2'd0;
      stop_mis_q <= 1'b0;
    end else if (fire) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      skip_q     <= skip_d;
      bit_q      <= bit_d;
      addr_q     <= addr_d;
      dir_q      <= dir_d;
      bytes_q    <= bytes_d;
      stop_pos_q <= stop_pos_d;
      stop_mis_q <= stop_mis_d;
    end
  end

  // Result register: load on the last sample, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Checks
  `I2CTD_ASSERT_SAME(a_status_range, clk_i, rst_ni, out_valid_q,
    res_q.status <= i2ctd_pkg::StAddrCut, "status code out of range")
  `I2CTD_ASSERT_SAME(a_fail_fields, clk_i, rst_ni,
    out_valid_q && res_q.status != i2ctd_pkg::StOk,
    !res_q.is_read && res_q.byte_count == 8'd0, "failed trace carries transfer fields")
  `I2CTD_ASSERT_SAME(a_skip_phase, clk_i, rst_ni, skip_q != 5'd0,
    phase_q == i2ctd_pkg::PhAddr || phase_q == i2ctd_pkg::PhRw ||
    phase_q == i2ctd_pkg::PhAack || phase_q == i2ctd_pkg::PhByte,
    "skip count active in a phase that never sets it")
  `I2CTD_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, fire && last,
    out_valid_q && phase_q == i2ctd_pkg::PhIdle && idx_q == '0,
    "trace state not cleared after report")

endmodule

[tb/i2ctd_trace_monitor.sv]
// Trace result checker for the I2C trace decoder: predicts and compares results.
`timescale 1ns / 1ps

module i2ctd_trace_monitor #(
  parameter int unsigned MaxSamples = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  i2ctd_pkg::sample_t  in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  i2ctd_pkg::result_t  out_res_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);

  // Predicted decoder state and its length register
  logic [11:0]       len_reg;
  i2ctd_pkg::phase_e dec_phase;
  logic [10:0]       pos_idx;
  logic [4:0]        skip_left;
  logic [2:0]        bit_idx;
  logic [6:0]        addr_sr;
  logic              rd_bit;
  logic [7:0]        byte_tally;
  logic [1:0]        stop_pos;
  logic              stop_bad;

  // Results predicted but not yet seen on the output
  i2ctd_pkg::result_t due_results[$];

  function automatic void clear_trace();
    dec_phase  = i2ctd_pkg::PhIdle;
    pos_idx    = '0;
    skip_left  = '0;
    bit_idx    = '0;
    addr_sr    = '0;
    rd_bit     = 1'b0;
    byte_tally = '0;
    stop_pos   = '0;
    stop_bad   = 1'b0;
  endfunction

  // Compare one closing sample against the fixed stop pattern
  function automatic void match_stop(input logic cl, input logic da);
    if (cl != i2ctd_pkg::StopClock[stop_pos] || da != i2ctd_pkg::StopData[stop_pos])
      stop_bad = 1'b1;
    stop_pos = stop_pos + 2'd1;
  endfunction

  // Advance the trace by one sample; on the trace's last sample produce its result
  task automatic decode_sample(input i2ctd_pkg::sample_t s, output bit produced,
                               output i2ctd_pkg::result_t res);
    int unsigned span;
    int unsigned idx;
    logic        cl;
    logic        da;
    logic [2:0]  st;
    cl = s.clock_line;
    da = s.data_line;
    span = (len_reg == 12'd0) ? 1 :
           ((32'(len_reg) > MaxSamples) ? MaxSamples : 32'(len_reg));
    idx = 32'(pos_idx);
    produced = 1'b0;
    res = '0;
    if (skip_left != 0) begin
      skip_left = skip_left - 5'd1;
    end else begin
      case (dec_phase)
        i2ctd_pkg::PhIdle: begin
          if (cl && !da) begin
            dec_phase = i2ctd_pkg::PhAddr;
            bit_idx = '0;
            addr_sr = '0;
          end
        end
        i2ctd_pkg::PhAddr: begin
          addr_sr = {addr_sr[5:0], da};
          if (bit_idx >= i2ctd_pkg::AddrLastBit) begin
            bit_idx = '0;
            dec_phase = i2ctd_pkg::PhRw;
          end else begin
            bit_idx = bit_idx + 3'd1;
          end
          skip_left = i2ctd_pkg::BitSkip;
        end
        i2ctd_pkg::PhRw: begin
          rd_bit = da;
          skip_left = i2ctd_pkg::AckSkip;
          dec_phase = i2ctd_pkg::PhAack;
        end
        i2ctd_pkg::PhAack: begin
          if (da) begin
            dec_phase = i2ctd_pkg::PhEndNoack;
          end else begin
            dec_phase = i2ctd_pkg::PhData;
            byte_tally = '0;
          end
        end
        i2ctd_pkg::PhData: begin
          if (idx + i2ctd_pkg::ByteSpan > span) begin
            if (idx + i2ctd_pkg::StopSpan == span) begin
              dec_phase = i2ctd_pkg::PhStop;
              stop_pos = '0;
              stop_bad = 1'b0;
              match_stop(cl, da);
            end else begin
              dec_phase = i2ctd_pkg::PhEndNostop;
            end
          end else begin
            if (byte_tally != 8'hff) byte_tally = byte_tally + 8'd1;
            skip_left = i2ctd_pkg::ByteSkip;
            dec_phase = i2ctd_pkg::PhByte;
          end
        end
        i2ctd_pkg::PhByte: begin
          if (cl && da) skip_left = i2ctd_pkg::BitSkip;
          else if (cl && !da) dec_phase = i2ctd_pkg::PhData;
          else dec_phase = i2ctd_pkg::PhWait;
        end
        i2ctd_pkg::PhWait: begin
          if (cl && !da) dec_phase = i2ctd_pkg::PhData;
        end
        i2ctd_pkg::PhStop: match_stop(cl, da);
        default: ;
      endcase
    end

    // Advance position until the last sample of the trace
    if (idx + 1 < span) begin
      pos_idx = 11'(idx + 1);
      return;
    end

    case (dec_phase)
      i2ctd_pkg::PhIdle:      st = i2ctd_pkg::StNoStart;
      i2ctd_pkg::PhAddr:      st = i2ctd_pkg::StAddrCut;
      i2ctd_pkg::PhRw,
      i2ctd_pkg::PhAack,
      i2ctd_pkg::PhEndNoack:  st = i2ctd_pkg::StNoAddrAck;
      i2ctd_pkg::PhData,
      i2ctd_pkg::PhEndNostop: st = i2ctd_pkg::StNoStop;
      i2ctd_pkg::PhStop:      st = (!stop_bad && stop_pos == 2'd0) ?
                                   i2ctd_pkg::StOk : i2ctd_pkg::StNoDataAck;
      default:                st = i2ctd_pkg::StNoDataAck;
    endcase
    res.status         = st;
    res.target_address = (st == i2ctd_pkg::StOk || st == i2ctd_pkg::StNoAddrAck) ?
                         addr_sr : '0;
    res.is_read        = (st == i2ctd_pkg::StOk) ? rd_bit : 1'b0;
    res.byte_count     = (st == i2ctd_pkg::StOk) ? byte_tally : '0;
    produced = 1'b1;
    clear_trace();
  endtask

  task automatic flag(input string what);
    errors_o++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) flag($sformatf("%s expected %0d, actual %0d", name, want, got));
  endtask

  // Track requests and config writes, compare each accepted result with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin
    bit                 produced;
    i2ctd_pkg::result_t want;
    i2ctd_pkg::result_t got;
    if (!rst_ni) begin
      len_reg = i2ctd_pkg::TraceLengthReset;
      clear_trace();
      due_results.delete();
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_sample(in_req_i, produced, want);
        if (produced) due_results.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_res_i;
        if (due_results.size() == 0) begin
          flag($sformatf("result expected none, actual status %0d address %0d bytes %0d",
                         got.status, got.target_address, got.byte_count));
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("target_address", 32'(want.target_address),
                      32'(got.target_address));
          check_field("is_read", 32'(want.is_read), 32'(got.is_read));
          check_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
        end
      end
      if (cfg_we_i) len_reg = cfg_wdata_i;
      pending_o = unsigned'(due_results.size());
    end
  end

endmodule

[tb/tb.sv]
// Top of the I2C trace decoder testbench: clock, reset, trace stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxSamples    = 2048;
  localparam int unsigned FrameOverhead = 23;  // start, address, direction, ack, stop
  localparam int unsigned ByteSamples   = 18;  // byte request, 16 skipped, clock-high sample
  localparam int unsigned RandomItems   = 1100;
  localparam int unsigned DrainCycles   = 4;

  localparam i2ctd_pkg::sample_t StartBit = 2'b10;  // clock high, data low
  localparam i2ctd_pkg::sample_t StopSeq [4] = '{2'b00, 2'b10, 2'b11, 2'b11};

  typedef enum int {FrWell, FrNoAck, FrBadStop, FrSkew, FrNoise} frame_kind_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [11:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  i2ctd_pkg::sample_t in_req;
  logic               out_valid;
  logic               out_stall;
  i2ctd_pkg::result_t out_res;
  int unsigned        pending;
  int unsigned        errors;

  i2ctd_pkg::sample_t frame_q[$];
  int unsigned        cur_span = 32'(i2ctd_pkg::TraceLengthReset);
  int unsigned        burst_left = 0;

  i2c_trace_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  i2ctd_trace_monitor #(.MaxSamples(MaxSamples)) monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_res_i   (out_res),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side in modes: none, light, heavy, periodic
  initial begin
    int unsigned mode_left;
    int unsigned stall_mode;
    mode_left = 0;
    stall_mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 300);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= mode_left[3];
      endcase
    end
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic i2ctd_pkg::sample_t noise();
    return 2'($urandom);
  endfunction

  // Random sample that can never read as a start or a byte release
  function automatic i2ctd_pkg::sample_t quiet();
    i2ctd_pkg::sample_t s;
    s = 2'($urandom);
    if (s == StartBit) s.data_line = 1'b1;
    return s;
  endfunction

  // Offer one request in bursts with random gaps; return at the negedge after acceptance
  task automatic send_sample(input i2ctd_pkg::sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result is out and the pipe is empty
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_length(input logic [11:0] value);
    pause_until_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_span = (value == 0) ? 1 : ((value > MaxSamples) ? MaxSamples : value);
  endtask

  // Build a bus transfer laid out for plan samples, then cut or pad it to the trace length
  task automatic build_frame(input frame_kind_e kind, input int unsigned plan, input bit fill);
    int unsigned nbytes;
    int unsigned slack;
    int unsigned lead;
    int unsigned hold;
    int unsigned k;
    logic [6:0]  addr;
    logic        rd;
    frame_q.delete();
    addr = 7'($urandom);
    rd = 1'($urandom);
    if (kind != FrNoise) begin
      nbytes = 0;
      if (plan >= FrameOverhead) begin
        nbytes = (plan - FrameOverhead) / ByteSamples;
        if (!fill) nbytes = $urandom_range(0, nbytes);
      end
      slack = (plan >= FrameOverhead + ByteSamples * nbytes)
              ? plan - FrameOverhead - ByteSamples * nbytes : 0;
      lead = (nbytes == 0) ? slack : $urandom_range(0, slack);
      slack -= lead;
      repeat (lead) frame_q.push_back(quiet());
      frame_q.push_back(StartBit);
      // address MSB first, each bit followed by a skipped sample
      for (int b = 6; b >= 0; b--) begin
        frame_q.push_back({1'($urandom), addr[b]});
        frame_q.push_back(noise());
      end
      frame_q.push_back({1'($urandom), rd});
      repeat (2) frame_q.push_back(noise());
      frame_q.push_back({1'($urandom), kind == FrNoAck});
      for (k = 0; k < nbytes; k++) begin
        hold = (k + 1 == nbytes) ? slack : $urandom_range(0, slack);
        slack -= hold;
        repeat (17) frame_q.push_back(noise());
        // stretch the byte: clock-high data-high retries, then a wait for release
        while (hold >= 2 && $urandom_range(0, 2) == 0) begin
          frame_q.push_back(2'b11);
          frame_q.push_back(noise());
          hold -= 2;
        end
        if (hold > 0) begin
          frame_q.push_back({1'b0, 1'($urandom)});
          repeat (hold - 1) frame_q.push_back(quiet());
        end
        frame_q.push_back(StartBit);
      end
      for (k = 0; k < 4; k++) frame_q.push_back(StopSeq[k]);
      if (kind == FrBadStop) begin
        k = frame_q.size() - 1 - $urandom_range(0, 3);
        frame_q[k] = frame_q[k] ^ 2'($urandom_range(1, 3));
      end
    end
    while (frame_q.size() > cur_span) void'(frame_q.pop_back());
    while (frame_q.size() < cur_span) frame_q.push_back(noise());
  endtask

  task automatic send_frame(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_sample(frame_q[i]);
  endtask

  task automatic run_frame(input frame_kind_e kind, input int unsigned plan, input bit fill);
    build_frame(kind, plan, fill);
    send_frame(cur_span);
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned pick;
    int unsigned len;
    int unsigned plan;
    frame_kind_e kind;
    rand_items = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Open a transfer at the reset length, then shrink the length under it
    build_frame(FrWell, 60, 1'b0);
    send_frame(30);
    set_length(12);
    send_sample(quiet());

    // One-sample traces: zero counts as one
    set_length(0);
    send_sample(StartBit);
    send_sample(2'b00);
    set_length(1);
    run_frame(FrNoise, 1, 1'b0);
    run_frame(FrNoise, 1, 1'b0);

    // Shortest full transfer: clean, broken stop, missing address ack
    set_length(FrameOverhead);
    run_frame(FrWell, FrameOverhead, 1'b0);
    run_frame(FrBadStop, FrameOverhead, 1'b0);
    run_frame(FrNoAck, FrameOverhead, 1'b0);

    // One data byte, then the same transfer cut inside the address and the ack,
    // and overrunning so the stop falls in the wrong place
    set_length(41);
    run_frame(FrWell, 41, 1'b1);
    run_frame(FrWell, 41, 1'b0);
    set_length(10);
    run_frame(FrWell, 41, 1'b1);
    set_length(18);
    run_frame(FrWell, 41, 1'b1);
    set_length(50);
    run_frame(FrWell, 41, 1'b1);

    // Cut the length while the stop pattern is half checked
    set_length(30);
    build_frame(FrWell, 30, 1'b0);
    send_frame(28);
    set_length(27);
    send_sample(quiet());

    // Largest register value clamps to the maximum trace; open a transfer, then close it
    set_length(12'hfff);
    build_frame(FrWell, 60, 1'b0);
    send_frame(40);
    set_length(FrameOverhead);
    send_sample(quiet());

    // Random traces, mostly well-formed transfers at small lengths
    while (rand_items < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) len = $urandom_range(0, FrameOverhead - 1);
      else if (pick < 9) len = $urandom_range(FrameOverhead, 130);
      else len = $urandom_range(131, 420);
      set_length(12'(len));
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 19);
        kind = (pick < 11) ? FrWell : (pick < 13) ? FrNoAck :
               (pick < 15) ? FrBadStop : (pick < 18) ? FrSkew : FrNoise;
        plan = (kind == FrSkew) ? $urandom_range(FrameOverhead, cur_span + 60) : cur_span;
        run_frame(kind, plan, 1'b0);
        rand_items += cur_span;
      end
    end

    pause_until_drained();
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/i2ctd_pkg.sv
rtl/i2c_trace_decoder.sv
tb/i2ctd_trace_monitor.sv
tb/tb.sv
